// ===== rtl/ptwc_pkg.sv =====
// Shared types, codes and constants for the page table walker with last-page caches.
package ptwc_pkg;

   localparam int REQ_TDATA_W = 152;  // 146 payload bits padded to whole bytes
   localparam int RSP_TDATA_W = 88;   // 85 payload bits padded to whole bytes
   localparam int IDX_BITS    = 9;    // 512 entries per table

   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   typedef enum logic [1:0] {
      OP_TRANSLATE   = 2'd0,
      OP_WRITE_TABLE = 2'd1,
      OP_WRITE_ROOT  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROOT,
      S_WALK,
      S_EMIT
   } state_type;

   // Table index of a virtual address at one walk level (bits 47:39 down to 20:12).
   function automatic logic [IDX_BITS-1:0] level_index(input logic [63:0] vaddr,
                                                       input logic [1:0]  level);
      logic [IDX_BITS-1:0] idx;
      case (level)
         2'd0:    idx = vaddr[47:39];
         2'd1:    idx = vaddr[38:30];
         2'd2:    idx = vaddr[29:21];
         default: idx = vaddr[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/page_table_walk_with_last_page_cache_core.sv =====
// Four-level page table walker with one-entry caches of the last small and large page.
// A cache hit is registered and then loaded into the response; a miss first takes a root read
// and one table store read per level. Writes are taken every cycle while idle; a translation
// blocks new requests until its response is loaded, and a stalled response holds the next one.
// Reset clears the walk state, cache valid bits and the response valid bit only.
// STORE_WORDS must be a power of two: table word indexes wrap by dropping high bits.
module page_table_walk_with_last_page_cache_core #(
   parameter int STORE_WORDS = 4096,
   parameter int CLIENTS     = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // client[5:0], vaddr[69:6], store_index[81:70], store_word[145:82], zero[151:146]
   input  logic [ptwc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // opcode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // page_entry[63:0], page_offset[84:64], zero[87:85]
   output logic [ptwc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // fault[0], large_page[1]
   output logic [1:0]                          rsp_tuser
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam int RW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

   // request fields
   logic [5:0]  req_client;
   logic [63:0] req_vaddr;
   logic [11:0] req_store_index;
   logic [63:0] req_store_word;

   assign req_client      = req_tdata[5:0];
   assign req_vaddr       = req_tdata[69:6];
   assign req_store_index = req_tdata[81:70];
   assign req_store_word  = req_tdata[145:82];

   // client number folded onto the root store
   logic [RW-1:0] client_map [64];
   for (genvar g = 0; g < 64; g++) begin : g_client_map
      assign client_map[g] = RW'(g % CLIENTS);
   end

   // memories
   logic [63:0] table_mem [STORE_WORDS];
   logic [63:0] root_mem  [CLIENTS];
   logic [63:0] tbl_rd_ff;
   logic [63:0] root_rd_ff;

   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   logic [AW-1:0] tbl_raddr;
   logic          root_we;
   logic [RW-1:0] root_addr;

   // control and payload registers
   ptwc_pkg::state_type state_ff, state_in;
   logic [1:0]  level_ff, level_in;
   logic [63:0] vaddr_ff;

   logic        small_valid_ff;
   logic [51:0] small_tag_ff;
   logic [63:0] small_frame_ff;
   logic        large_valid_ff;
   logic [42:0] large_tag_ff;
   logic [63:0] large_frame_ff;

   logic        res_fault_ff, res_large_ff;
   logic [63:0] res_entry_ff;
   logic [20:0] res_offset_ff;

   logic        rsp_valid_ff;
   logic        rsp_fault_ff, rsp_large_ff;
   logic [63:0] rsp_entry_ff;
   logic [20:0] rsp_offset_ff;

   // combinational controls
   logic        accept;
   logic        small_hit, large_hit;
   logic [16:0] sidx_ext;
   logic        finish, fill_small, fill_large, load_rsp;
   logic        fin_fault, fin_large;
   logic [63:0] fin_entry;
   logic [20:0] fin_offset;
   logic [63:0] walk_entry, walk_cleared;

   assign accept     = req_tvalid && req_tready;
   assign small_hit  = small_valid_ff && (small_tag_ff == req_vaddr[63:12]);
   assign large_hit  = large_valid_ff && (large_tag_ff == req_vaddr[63:21]);
   assign sidx_ext   = 17'(req_store_index);
   assign walk_entry = tbl_rd_ff;
   assign walk_cleared = {1'b0, tbl_rd_ff[62:0]};
   assign tbl_waddr  = sidx_ext[AW-1:0];
   assign root_addr  = client_map[req_client];

   always_comb begin
      state_in   = state_ff;
      level_in   = level_ff;
      req_tready = 1'b0;
      tbl_we     = 1'b0;
      root_we    = 1'b0;
      tbl_raddr  = '0;
      finish     = 1'b0;
      fill_small = 1'b0;
      fill_large = 1'b0;
      load_rsp   = 1'b0;
      fin_fault  = 1'b0;
      fin_large  = 1'b0;
      fin_entry  = '0;
      fin_offset = '0;
      unique case (state_ff)
         ptwc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               case (req_tuser)
                  ptwc_pkg::OP_WRITE_TABLE: begin
                     tbl_we = (sidx_ext < 17'(STORE_WORDS));
                  end
                  ptwc_pkg::OP_WRITE_ROOT: begin
                     root_we = 1'b1;
                  end
                  ptwc_pkg::OP_TRANSLATE: begin
                     if (small_hit) begin
                        finish     = 1'b1;
                        fin_entry  = small_frame_ff;
                        fin_offset = 21'(req_vaddr[11:0]);
                     end else if (large_hit) begin
                        finish     = 1'b1;
                        fin_large  = 1'b1;
                        fin_entry  = large_frame_ff;
                        fin_offset = req_vaddr[20:0];
                     end else begin
                        state_in = ptwc_pkg::S_ROOT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptwc_pkg::S_ROOT: begin
            tbl_raddr = root_rd_ff[AW+2:3] + AW'(ptwc_pkg::level_index(vaddr_ff, 2'd0));
            level_in  = 2'd0;
            state_in  = ptwc_pkg::S_WALK;
         end
         ptwc_pkg::S_WALK: begin
            if (walk_entry == ptwc_pkg::ALL_ONES) begin
               finish    = 1'b1;
               fin_fault = 1'b1;
            end else if (level_ff == 2'd3) begin
               finish = 1'b1;
               if (walk_entry == '0) begin
                  fin_fault = 1'b1;
               end else begin
                  fill_small = 1'b1;
                  fin_entry  = walk_entry;
                  fin_offset = 21'(vaddr_ff[11:0]);
               end
            end else if ((level_ff == 2'd2) && walk_entry[63]) begin
               finish = 1'b1;
               if (walk_cleared == '0) begin
                  fin_fault = 1'b1;
               end else begin
                  fill_large = 1'b1;
                  fin_large  = 1'b1;
                  fin_entry  = walk_cleared;
                  fin_offset = vaddr_ff[20:0];
               end
            end else begin
               // descend: the entry is the byte offset of the next table
               tbl_raddr = walk_entry[AW+2:3]
                         + AW'(ptwc_pkg::level_index(vaddr_ff, level_ff + 2'd1));
               level_in  = level_ff + 2'd1;
            end
         end
         ptwc_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ptwc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptwc_pkg::S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = ptwc_pkg::S_EMIT;
      end
   end

   // table store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= req_store_word;
      end
      tbl_rd_ff <= table_mem[tbl_raddr];
   end

   // root store
   always_ff @(posedge clock) begin
      if (root_we) begin
         root_mem[root_addr] <= req_store_word;
      end
      root_rd_ff <= root_mem[root_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ptwc_pkg::S_IDLE;
         level_ff       <= '0;
         small_valid_ff <= 1'b0;
         large_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (fill_small) begin
            small_valid_ff <= 1'b1;
         end
         if (fill_large) begin
            large_valid_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vaddr_ff <= req_vaddr;
      end
      if (fill_small) begin
         small_tag_ff   <= vaddr_ff[63:12];
         small_frame_ff <= walk_entry;
      end
      if (fill_large) begin
         large_tag_ff   <= vaddr_ff[63:21];
         large_frame_ff <= walk_cleared;
      end
      if (finish) begin
         res_fault_ff  <= fin_fault;
         res_large_ff  <= fin_large;
         res_entry_ff  <= fin_entry;
         res_offset_ff <= fin_offset;
      end
      if (load_rsp) begin
         rsp_fault_ff  <= res_fault_ff;
         rsp_large_ff  <= res_large_ff;
         rsp_entry_ff  <= res_entry_ff;
         rsp_offset_ff <= res_offset_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_offset_ff, rsp_entry_ff};
   assign rsp_tuser  = {rsp_large_ff, rsp_fault_ff};

endmodule

// ===== rtl/ptwc_checker.sv =====
// Port-level checks for the page table walker core, bound to the core module.
module ptwc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ptwc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   // no response survives reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a fault carries no page
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("fault response with page data");

   // a small page offset stays within 4 KiB, and a good page is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && !rsp_tuser[1] |->
         (rsp_tdata[84:76] == '0) && (rsp_tdata[63:0] != '0))
      else $error("bad small page response");

   // a table write request never yields a response on the next cycle by itself
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ptwc_pkg::OP_WRITE_TABLE) && !rsp_tvalid
         |=> !rsp_tvalid)
      else $error("response after table write");

endmodule

bind page_table_walk_with_last_page_cache_core ptwc_checker u_ptwc_checker (.*);
